[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL of the peak threshold counter
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check on every clock edge, reset included
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[rtl/ptfc_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptfc_pkg
// Types, constants and helpers for the channel peak threshold flag counter.
// ---------------------------------------------------------------------------
package ptfc_pkg;

    localparam int CHANNELS   = 64;
    localparam int COUNT_BITS = 24;

    localparam int CH_W      = 6;
    localparam int CH_BITS   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PED_DEPTH = 2 << CH_BITS;
    localparam int PED_W     = 32;
    localparam int CNT_W3    = 3 * COUNT_BITS;
    localparam int OUT_BITS  = 24;
    localparam int THR_W     = 26;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR   = $clog2(CMDQ_DEPTH);
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR   = $clog2(OUTQ_DEPTH);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [OUT_BITS-1:0]   OUT_MAX = '1;

    localparam logic [7:0]  SIGMA_CUT_RST = 8'd48;
    localparam logic [15:0] SKIP_RST      = 16'd100;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_LOAD   = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic {
        CFG_SIGMA_CUT      = 1'b0,
        CFG_EVENTS_TO_SKIP = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        CMD_CLOSE = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_kind_t;

    // Command word passed from the front end to the back end
    typedef struct packed {
        cmd_kind_t             kind;
        logic [CH_W-1:0]       channel;
        logic                  integ;
        logic                  bb;
        logic                  bg;
        logic [9:0]            peak;
        logic [15:0]           mean;
        logic [15:0]           sigma;
        logic [COUNT_BITS-1:0] tally;
    } cmd_t;

    typedef struct packed {
        logic [CH_W-1:0]     read_channel;
        logic [OUT_BITS-1:0] hit_total;
        logic [OUT_BITS-1:0] beam_beam_total;
        logic [OUT_BITS-1:0] beam_gas_total;
        logic [OUT_BITS-1:0] events_seen;
    } res_t;

    function automatic logic [CH_BITS-1:0] ch_addr(input logic [CH_W-1:0] ch);
        logic [8:0] wide;
        wide = {3'b000, ch};
        return wide[CH_BITS-1:0];
    endfunction

    function automatic logic ch_in_range(input logic [CH_W-1:0] ch);
        return {3'b000, ch} < 9'(CHANNELS);
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [OUT_BITS-1:0] clamp_out(input logic [COUNT_BITS-1:0] v);
        logic [31:0] wide;
        wide = 32'(v);
        return (wide > 32'(OUT_MAX)) ? OUT_MAX : wide[OUT_BITS-1:0];
    endfunction

endpackage

[rtl/channel_peak_threshold_flag_counter_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// channel_peak_threshold_flag_counter_core
// Per-channel peak finder with pedestal threshold and saturating counters.
// ---------------------------------------------------------------------------
// Usage:
//   s_* carries one word per clock: a sample, a pedestal load, a counter
//   read or a counter clear, selected by s_operation. m_* returns one word
//   for each counter read. cfg_* writes sigma_cut (index 0) and
//   events_to_skip (index 1); cfg_ready is always high, write only when idle.
//   Throughput is one word per clock on both sides while s_ready and m_ready
//   are high. A read result passes through the command queue, the pedestal
//   RAM read and threshold stage, and the counter RAM read-modify-write
//   stage, which fills the output buffer that drives m_*.
//   Reset zeroes all counters at once (a valid bit per channel), restores
//   the register defaults and rearms peak tracking. The pedestal tables
//   hold nothing until loaded; load every entry used before counting.
//   When m_ready is low, up to four results wait in the output buffer;
//   further reads then hold in the four-word command queue, and s_ready
//   drops once that queue is full.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module channel_peak_threshold_flag_counter_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [5:0]  s_channel,
    input  logic [9:0]  s_sample_value,
    input  logic        s_integrator_flag,
    input  logic        s_beam_beam_flag,
    input  logic        s_beam_gas_flag,
    input  logic        s_last_of_channel,
    input  logic        s_last_of_event,
    input  logic [15:0] s_pedestal_mean_in,
    input  logic [15:0] s_pedestal_sigma_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_read_channel,
    output logic [23:0] m_hit_total,
    output logic [23:0] m_beam_beam_total,
    output logic [23:0] m_beam_gas_total,
    output logic [23:0] m_events_seen,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import ptfc_pkg::*;

    logic [7:0]  sigma_cut_reg;
    logic [15:0] events_to_skip_reg;

    logic cmd_push;
    logic cmd_room;
    cmd_t cmd_in;
    logic cmd_avail;
    logic cmd_take;
    cmd_t cmd_out;
    res_t res;
    logic read_taken;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sigma_cut_reg      <= SIGMA_CUT_RST;
            events_to_skip_reg <= SKIP_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SIGMA_CUT:      sigma_cut_reg      <= cfg_data[7:0];
                CFG_EVENTS_TO_SKIP: events_to_skip_reg <= cfg_data;
            endcase
        end
    end

    ptfc_front u_front (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_operation         (s_operation),
        .s_channel           (s_channel),
        .s_sample_value      (s_sample_value),
        .s_integrator_flag   (s_integrator_flag),
        .s_beam_beam_flag    (s_beam_beam_flag),
        .s_beam_gas_flag     (s_beam_gas_flag),
        .s_last_of_channel   (s_last_of_channel),
        .s_last_of_event     (s_last_of_event),
        .s_pedestal_mean_in  (s_pedestal_mean_in),
        .s_pedestal_sigma_in (s_pedestal_sigma_in),
        .events_to_skip      (events_to_skip_reg),
        .q_ready             (cmd_room),
        .q_valid             (cmd_push),
        .q_cmd               (cmd_in)
    );

    ptfc_cmd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cmd_push),
        .in_ready  (cmd_room),
        .in_cmd    (cmd_in),
        .out_valid (cmd_avail),
        .out_ready (cmd_take),
        .out_cmd   (cmd_out)
    );

    ptfc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (cmd_avail),
        .q_ready   (cmd_take),
        .q_cmd     (cmd_out),
        .sigma_cut (sigma_cut_reg),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (res)
    );

    assign m_read_channel    = res.read_channel;
    assign m_hit_total       = res.hit_total;
    assign m_beam_beam_total = res.beam_beam_total;
    assign m_beam_gas_total  = res.beam_gas_total;
    assign m_events_seen     = res.events_seen;

    assign read_taken = s_valid && s_ready && (s_operation == OP_READ);

    `ASSERT_CLK_ALWAYS(a_reset_empties_output, !aresetn |=> !m_valid, "valid after reset")
    `ASSERT_CLK(a_push_has_room, cmd_push |-> cmd_room, "command pushed into a full queue")
    `ASSERT_CLK(a_read_queued, read_taken |-> cmd_push, "read word produced no command")

endmodule

[rtl/ptfc_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptfc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module ptfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/ptfc_cmd_queue.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptfc_cmd_queue
// Short FIFO of command words between the front end and the back end.
// ---------------------------------------------------------------------------
module ptfc_cmd_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  ptfc_pkg::cmd_t  in_cmd,
    output logic            out_valid,
    input  logic            out_ready,
    output ptfc_pkg::cmd_t  out_cmd
);
    import ptfc_pkg::*;

    cmd_t                slot_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR-1:0] wr_ptr_reg;
    logic [CMDQ_PTR-1:0] rd_ptr_reg;
    logic [CMDQ_PTR:0]   count_reg;
    logic                push;
    logic                pop;

    assign in_ready  = (count_reg != (CMDQ_PTR + 1)'(CMDQ_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

[rtl/ptfc_front.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptfc_front
// Accepts input words, tracks the channel peak and event count, and turns
// each word into at most one command for the back end.
// ---------------------------------------------------------------------------
module ptfc_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_operation,
    input  logic [5:0]          s_channel,
    input  logic [9:0]          s_sample_value,
    input  logic                s_integrator_flag,
    input  logic                s_beam_beam_flag,
    input  logic                s_beam_gas_flag,
    input  logic                s_last_of_channel,
    input  logic                s_last_of_event,
    input  logic [15:0]         s_pedestal_mean_in,
    input  logic [15:0]         s_pedestal_sigma_in,
    input  logic [15:0]         events_to_skip,
    input  logic                q_ready,
    output logic                q_valid,
    output ptfc_pkg::cmd_t      q_cmd
);
    import ptfc_pkg::*;

    logic [9:0]            peak_reg;
    logic [2:0]            flags_reg;
    logic                  start_reg;
    logic [COUNT_BITS-1:0] tally_reg;

    op_t        op;
    logic       accept;
    logic       take_new;
    logic [9:0] peak_now;
    logic [2:0] flags_now;
    logic       closing;
    logic       in_window;
    logic       want_cmd;

    assign s_ready  = q_ready;
    assign accept   = s_valid && s_ready;
    assign op       = op_t'(s_operation);
    assign closing  = s_last_of_channel || s_last_of_event;

    // Ties keep the earliest sample of the channel
    assign take_new  = start_reg || (s_sample_value > peak_reg);
    assign peak_now  = take_new ? s_sample_value : peak_reg;
    assign flags_now = take_new
                     ? {s_beam_gas_flag, s_beam_beam_flag, s_integrator_flag}
                     : flags_reg;
    assign in_window = (32'(tally_reg) >= 32'(events_to_skip));

    always_comb begin
        q_cmd         = '0;
        q_cmd.channel = s_channel;
        q_cmd.tally   = tally_reg;
        want_cmd      = 1'b0;
        unique case (op)
            OP_SAMPLE: begin
                q_cmd.kind  = CMD_CLOSE;
                q_cmd.peak  = peak_now;
                q_cmd.integ = flags_now[0];
                q_cmd.bb    = flags_now[1];
                q_cmd.bg    = flags_now[2];
                want_cmd    = closing && in_window && ch_in_range(s_channel);
            end
            OP_LOAD: begin
                q_cmd.kind  = CMD_LOAD;
                q_cmd.integ = s_integrator_flag;
                q_cmd.mean  = s_pedestal_mean_in;
                q_cmd.sigma = s_pedestal_sigma_in;
                want_cmd    = ch_in_range(s_channel);
            end
            OP_READ: begin
                q_cmd.kind = CMD_READ;
                want_cmd   = 1'b1;
            end
            OP_CLEAR: begin
                q_cmd.kind = CMD_CLEAR;
                want_cmd   = 1'b1;
            end
        endcase
    end

    assign q_valid = accept && want_cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_reg  <= '0;
            flags_reg <= '0;
            start_reg <= 1'b1;
            tally_reg <= '0;
        end else if (accept) begin
            if (op == OP_SAMPLE) begin
                peak_reg  <= peak_now;
                flags_reg <= flags_now;
                start_reg <= closing;
                if (s_last_of_event) begin
                    tally_reg <= sat_inc(tally_reg);
                end
            end else if (op == OP_CLEAR) begin
                tally_reg <= '0;
            end
        end
    end

endmodule

[rtl/ptfc_back.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptfc_back
// Executes commands: pedestal loads, threshold compare and counter update,
// counter reads and clears. Three stages plus a small result buffer.
// ---------------------------------------------------------------------------
module ptfc_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    output logic            q_ready,
    input  ptfc_pkg::cmd_t  q_cmd,
    input  logic [7:0]      sigma_cut,
    output logic            m_valid,
    input  logic            m_ready,
    output ptfc_pkg::res_t  m_res
);
    import ptfc_pkg::*;

    // Pipeline
    logic              s1_valid_reg;
    cmd_t              s1_cmd_reg;
    logic              s2_valid_reg;
    cmd_t              s2_cmd_reg;
    logic [THR_W-1:0]  s2_thr_reg;

    // Counter bookkeeping
    logic [CHANNELS-1:0] entry_valid_reg;
    logic                fwd_valid_reg;
    logic [CH_BITS-1:0]  fwd_addr_reg;
    logic [CNT_W3-1:0]   fwd_data_reg;

    // Result buffer
    res_t                slot_reg [OUTQ_DEPTH];
    logic [OUTQ_PTR-1:0] wr_ptr_reg;
    logic [OUTQ_PTR-1:0] rd_ptr_reg;
    logic [OUTQ_PTR:0]   count_reg;

    logic                  pop;
    logic [OUTQ_PTR+1:0]   pending;
    logic                  room;
    logic [CH_BITS:0]      ped_addr;
    logic [PED_W-1:0]      ped_rdata;
    logic [23:0]           prod;
    logic [THR_W-1:0]      thr_next;
    logic [CH_BITS-1:0]    a2;
    logic [CNT_W3-1:0]     cnt_rdata;
    logic [CNT_W3-1:0]     cur;
    logic [COUNT_BITS-1:0] cur_hit;
    logic [COUNT_BITS-1:0] cur_bb;
    logic [COUNT_BITS-1:0] cur_bg;
    logic [CNT_W3-1:0]     upd;
    logic                  over;
    logic                  do_write;
    logic                  do_clear;
    logic                  res_push;
    logic                  res_pop;
    res_t                  res;

    // Admit a read only when its result is sure to find a buffer slot
    assign pending = (OUTQ_PTR + 2)'(count_reg)
                   + (OUTQ_PTR + 2)'(s1_valid_reg && (s1_cmd_reg.kind == CMD_READ))
                   + (OUTQ_PTR + 2)'(s2_valid_reg && (s2_cmd_reg.kind == CMD_READ));
    assign room    = (pending < (OUTQ_PTR + 2)'(OUTQ_DEPTH));
    assign q_ready = (q_cmd.kind != CMD_READ) || room;
    assign pop     = q_valid && q_ready;

    // Stage 0: pedestal write or read
    assign ped_addr = {q_cmd.integ, ch_addr(q_cmd.channel)};

    ptfc_ram #(
        .WIDTH (PED_W),
        .DEPTH (PED_DEPTH)
    ) u_ped_ram (
        .aclk    (aclk),
        .wr_en   (pop && (q_cmd.kind == CMD_LOAD)),
        .wr_addr (ped_addr),
        .wr_data ({q_cmd.mean, q_cmd.sigma}),
        .rd_addr (ped_addr),
        .rd_data (ped_rdata)
    );

    // Stage 1: threshold in Q.10, mean in Q.6 shifted up plus sigma_cut * sigma
    assign prod     = 24'(sigma_cut) * 24'(ped_rdata[15:0]);
    assign thr_next = THR_W'({ped_rdata[31:16], 4'b0000}) + THR_W'(prod);

    always_ff @(posedge aclk) begin
        s1_cmd_reg <= q_cmd;
        s2_cmd_reg <= s1_cmd_reg;
        s2_thr_reg <= thr_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= pop;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Stage 2: counter read-modify-write
    assign a2 = ch_addr(s2_cmd_reg.channel);

    ptfc_ram #(
        .WIDTH (CNT_W3),
        .DEPTH (CHANNELS)
    ) u_cnt_ram (
        .aclk    (aclk),
        .wr_en   (do_write),
        .wr_addr (a2),
        .wr_data (upd),
        .rd_addr (ch_addr(s1_cmd_reg.channel)),
        .rd_data (cnt_rdata)
    );

    // Bypass last cycle's write; an entry not written since clear reads zero
    always_comb begin
        if (fwd_valid_reg && (fwd_addr_reg == a2)) begin
            cur = fwd_data_reg;
        end else if (entry_valid_reg[a2]) begin
            cur = cnt_rdata;
        end else begin
            cur = '0;
        end
    end

    assign cur_hit = cur[COUNT_BITS-1:0];
    assign cur_bb  = cur[2*COUNT_BITS-1:COUNT_BITS];
    assign cur_bg  = cur[CNT_W3-1:2*COUNT_BITS];

    assign over = (THR_W'({s2_cmd_reg.peak, 10'b0}) > s2_thr_reg);
    assign upd  = {s2_cmd_reg.bg ? sat_inc(cur_bg) : cur_bg,
                   s2_cmd_reg.bb ? sat_inc(cur_bb) : cur_bb,
                   sat_inc(cur_hit)};

    assign do_write = s2_valid_reg && (s2_cmd_reg.kind == CMD_CLOSE) && over;
    assign do_clear = s2_valid_reg && (s2_cmd_reg.kind == CMD_CLEAR);
    assign res_push = s2_valid_reg && (s2_cmd_reg.kind == CMD_READ);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= '0;
            fwd_valid_reg   <= 1'b0;
        end else begin
            fwd_valid_reg <= do_write;
            if (do_clear) begin
                entry_valid_reg <= '0;
            end else if (do_write) begin
                entry_valid_reg[a2] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        fwd_addr_reg <= a2;
        fwd_data_reg <= upd;
    end

    always_comb begin
        res.read_channel = s2_cmd_reg.channel;
        res.events_seen  = clamp_out(s2_cmd_reg.tally);
        if (ch_in_range(s2_cmd_reg.channel)) begin
            res.hit_total       = clamp_out(cur_hit);
            res.beam_beam_total = clamp_out(cur_bb);
            res.beam_gas_total  = clamp_out(cur_bg);
        end else begin
            res.hit_total       = '0;
            res.beam_beam_total = '0;
            res.beam_gas_total  = '0;
        end
    end

    // Result buffer
    assign m_valid = (count_reg != '0);
    assign m_res   = slot_reg[rd_ptr_reg];
    assign res_pop = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (res_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (res_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (res_push && !res_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (res_pop && !res_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_push) begin
            slot_reg[wr_ptr_reg] <= res;
        end
    end

endmodule

[verif/tb_channel_peak_threshold_flag_counter_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_channel_peak_threshold_flag_counter_core
// Self-checking bench for the per-channel peak threshold flag counter.
// Loads the whole pedestal table, walks a short table of directed words
// (reset state, table extremes, tied peaks, silent channels, end of event,
// skip window, clear), then runs phases of random events under several
// register settings. Each counter read coming back is checked field by
// field against the cycle-free bench model or a fixed expected result.
// ---------------------------------------------------------------------------
module tb_channel_peak_threshold_flag_counter_core;

    import ptfc_pkg::*;

    typedef struct {
        op_t         op;
        logic [5:0]  ch;
        logic [9:0]  val;
        logic        integ;
        logic        bb;
        logic        bg;
        logic        lch;
        logic        lev;
        logic [15:0] mean;
        logic [15:0] sigma;
    } word_t;

    typedef enum logic {
        ROW_WORD = 1'b0,
        ROW_REGS = 1'b1
    } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        word_t       w;
        logic [15:0] cut_data;
        logic [15:0] skip_data;
        bit          typed;
        res_t        want;
    } plan_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_operation;
    logic [5:0]  s_channel;
    logic [9:0]  s_sample_value;
    logic        s_integrator_flag;
    logic        s_beam_beam_flag;
    logic        s_beam_gas_flag;
    logic        s_last_of_channel;
    logic        s_last_of_event;
    logic [15:0] s_pedestal_mean_in;
    logic [15:0] s_pedestal_sigma_in;
    logic        m_valid;
    logic        m_ready;
    logic [5:0]  m_read_channel;
    logic [23:0] m_hit_total;
    logic [23:0] m_beam_beam_total;
    logic [23:0] m_beam_gas_total;
    logic [23:0] m_events_seen;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [15:0] cfg_data;

    // Counter model state
    logic [15:0] ped_mean  [2*CHANNELS];
    logic [15:0] ped_sigma [2*CHANNELS];
    logic [23:0] hit_cnt   [CHANNELS];
    logic [23:0] bb_cnt    [CHANNELS];
    logic [23:0] bg_cnt    [CHANNELS];
    logic [23:0] event_cnt;
    logic [9:0]  pk_val;
    logic [2:0]  pk_flags;
    logic        ch_fresh;
    logic [7:0]  cut;
    logic [15:0] skip_n;

    res_t      pending_reads [$];
    plan_row_t plan_rows [$];

    int  errors        = 0;
    int  words_sent    = 0;
    int  reads_checked = 0;
    int  reg_settings  = 0;
    int  closes_scored = 0;
    int  hits_scored   = 0;
    bit  steady        = 1'b0;
    bit  hold_off_req  = 1'b0;

    channel_peak_threshold_flag_counter_core i_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_operation         (s_operation),
        .s_channel           (s_channel),
        .s_sample_value      (s_sample_value),
        .s_integrator_flag   (s_integrator_flag),
        .s_beam_beam_flag    (s_beam_beam_flag),
        .s_beam_gas_flag     (s_beam_gas_flag),
        .s_last_of_channel   (s_last_of_channel),
        .s_last_of_event     (s_last_of_event),
        .s_pedestal_mean_in  (s_pedestal_mean_in),
        .s_pedestal_sigma_in (s_pedestal_sigma_in),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_read_channel      (m_read_channel),
        .m_hit_total         (m_hit_total),
        .m_beam_beam_total   (m_beam_beam_total),
        .m_beam_gas_total    (m_beam_gas_total),
        .m_events_seen       (m_events_seen),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [23:0] count_up(input logic [23:0] v);
        return (v == 24'hFFFFFF) ? v : v + 24'd1;
    endfunction

    function automatic res_t totals(input logic [5:0] ch, input logic [23:0] h,
                                    input logic [23:0] b, input logic [23:0] g,
                                    input logic [23:0] e);
        res_t r;
        r.read_channel    = ch;
        r.hit_total       = h;
        r.beam_beam_total = b;
        r.beam_gas_total  = g;
        r.events_seen     = e;
        return r;
    endfunction

    // flags are {beam_gas, beam_beam, integrator}
    function automatic word_t mk_word(input op_t op, input logic [5:0] ch,
                                      input logic [9:0] val, input logic [2:0] flags,
                                      input logic lch, input logic lev,
                                      input logic [15:0] mean, input logic [15:0] sigma);
        word_t w;
        w.op    = op;
        w.ch    = ch;
        w.val   = val;
        w.integ = flags[0];
        w.bb    = flags[1];
        w.bg    = flags[2];
        w.lch   = lch;
        w.lev   = lev;
        w.mean  = mean;
        w.sigma = sigma;
        return w;
    endfunction

    function automatic logic [15:0] pick_mean();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return 16'h0000;
        if (r == 1) return 16'hFFFF;
        return 16'($urandom_range(0, 16'h6000));
    endfunction

    function automatic logic [15:0] pick_sigma();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return 16'h0000;
        if (r == 1) return 16'hFFFF;
        return 16'($urandom_range(0, 1500));
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(input string field, input logic [23:0] got,
                                   input logic [23:0] want);
        $display("mismatch on %s: got %0d, expected %0d", field, got, want);
        errors++;
    endtask

    task automatic wipe_counters();
        foreach (hit_cnt[i]) begin
            hit_cnt[i] = '0;
            bb_cnt[i]  = '0;
            bg_cnt[i]  = '0;
        end
        event_cnt = '0;
    endtask

    // Advance the counter model by one accepted word
    task automatic predict_word(input word_t w, output bit has_res, output res_t res);
        logic [6:0]  idx;
        logic [31:0] thr;
        logic [31:0] pk;
        has_res = 1'b0;
        res     = '0;
        case (w.op)
            OP_SAMPLE: begin
                // strictly greater: a tie keeps the earliest sample's flags
                if (ch_fresh || w.val > pk_val) begin
                    pk_val   = w.val;
                    pk_flags = {w.bg, w.bb, w.integ};
                end
                ch_fresh = 1'b0;
                // end of event closes the open channel as well
                if (w.lch || w.lev) begin
                    if (event_cnt >= 24'(skip_n)) begin
                        idx = {pk_flags[0], w.ch};
                        thr = {12'd0, ped_mean[idx], 4'd0}
                            + 32'(cut) * 32'(ped_sigma[idx]);
                        pk  = {12'd0, pk_val, 10'd0};
                        closes_scored++;
                        if (pk > thr) begin
                            hits_scored++;
                            hit_cnt[w.ch] = count_up(hit_cnt[w.ch]);
                            if (pk_flags[1]) bb_cnt[w.ch] = count_up(bb_cnt[w.ch]);
                            if (pk_flags[2]) bg_cnt[w.ch] = count_up(bg_cnt[w.ch]);
                        end
                    end
                    ch_fresh = 1'b1;
                end
                if (w.lev) event_cnt = count_up(event_cnt);
            end
            OP_LOAD: begin
                idx = {w.integ, w.ch};
                ped_mean[idx]  = w.mean;
                ped_sigma[idx] = w.sigma;
            end
            OP_READ: begin
                has_res = 1'b1;
                res = totals(w.ch, hit_cnt[w.ch], bb_cnt[w.ch], bg_cnt[w.ch], event_cnt);
            end
            default: begin
                wipe_counters();
            end
        endcase
    endtask

    // Offer one word after a random gap and hold it until taken
    task automatic send_word(input word_t w, input bit typed, input res_t want);
        int   gap;
        bit   has_res;
        res_t res;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid             <= 1'b1;
        s_operation         <= w.op;
        s_channel           <= w.ch;
        s_sample_value      <= w.val;
        s_integrator_flag   <= w.integ;
        s_beam_beam_flag    <= w.bb;
        s_beam_gas_flag     <= w.bg;
        s_last_of_channel   <= w.lch;
        s_last_of_event     <= w.lev;
        s_pedestal_mean_in  <= w.mean;
        s_pedestal_sigma_in <= w.sigma;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
        predict_word(w, has_res, res);
        if (has_res) pending_reads.push_back(typed ? want : res);
    endtask

    // Stop offering and wait for every outstanding read plus pipeline slack
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_reads.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic set_regs(input logic [15:0] cut_data, input logic [15:0] skip_data);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_SIGMA_CUT;
        cfg_data  <= cut_data;
        do @(posedge aclk); while (!cfg_ready);
        cut = cut_data[7:0];
        cfg_index <= CFG_EVENTS_TO_SKIP;
        cfg_data  <= skip_data;
        do @(posedge aclk); while (!cfg_ready);
        skip_n = skip_data;
        cfg_valid <= 1'b0;
        reg_settings++;
    endtask

    task automatic plan_word(input word_t w);
        plan_row_t r;
        r.kind  = ROW_WORD;
        r.w     = w;
        r.typed = 1'b0;
        plan_rows.push_back(r);
    endtask

    task automatic plan_check(input word_t w, input res_t want);
        plan_row_t r;
        r.kind  = ROW_WORD;
        r.w     = w;
        r.typed = 1'b1;
        r.want  = want;
        plan_rows.push_back(r);
    endtask

    task automatic plan_regs(input logic [15:0] cut_data, input logic [15:0] skip_data);
        plan_row_t r;
        r.kind      = ROW_REGS;
        r.cut_data  = cut_data;
        r.skip_data = skip_data;
        r.typed     = 1'b0;
        plan_rows.push_back(r);
    endtask

    // Random traffic: mostly well-formed events, then loads, noise and stray reads
    task automatic run_traffic(input int n_words);
        int         start;
        int         r;
        int         nch;
        int         nsamp;
        int         mode;
        int         nrd;
        bit         end_by_event;
        logic [5:0] ch;
        logic [9:0] base;
        logic [9:0] val;
        logic [5:0] used [$];
        op_t        op;
        start = words_sent;
        while (words_sent - start < n_words) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                nch = $urandom_range(1, 5);
                used.delete();
                for (int c = 0; c < nch; c++) begin
                    // favour a few channels so their counters climb
                    ch = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                     : 6'($urandom_range(0, 7));
                    nsamp = $urandom_range(1, 6);
                    mode  = $urandom_range(0, 7);
                    base  = 10'($urandom_range(0, 1023));
                    end_by_event = (c == nch - 1) && ($urandom_range(0, 5) == 0);
                    for (int s = 0; s < nsamp; s++) begin
                        if (mode < 5) val = 10'($urandom_range(0, 1023));
                        else if (mode < 7) val = base ^ 10'($urandom_range(0, 1) * 
                                                             $urandom_range(0, 3));
                        else val = 10'd0;
                        send_word(mk_word(OP_SAMPLE, ch, val, 3'($urandom),
                                          (s == nsamp - 1) && !end_by_event,
                                          (s == nsamp - 1) && (c == nch - 1),
                                          16'($urandom), 16'($urandom)), 1'b0, '0);
                    end
                    used.push_back(ch);
                end
                nrd = $urandom_range(1, 2);
                for (int k = 0; k < nrd; k++) begin
                    ch = used[$urandom_range(0, used.size() - 1)];
                    send_word(mk_word(OP_READ, ch, 10'($urandom), 3'($urandom),
                                      1'($urandom), 1'($urandom), 16'($urandom),
                                      16'($urandom)), 1'b0, '0);
                end
            end else if (r < 80) begin
                send_word(mk_word(OP_LOAD, 6'($urandom), 10'($urandom), 3'($urandom),
                                  1'($urandom), 1'($urandom), pick_mean(), pick_sigma()),
                          1'b0, '0);
            end else if (r < 95) begin
                // broken sequences: random words, random ends, rare clears
                op = op_t'($urandom_range(0, 3));
                if (op == OP_CLEAR && $urandom_range(0, 3) != 0) op = OP_SAMPLE;
                send_word(mk_word(op, 6'($urandom), 10'($urandom), 3'($urandom),
                                  1'($urandom), 1'($urandom), pick_mean(), pick_sigma()),
                          1'b0, '0);
            end else begin
                send_word(mk_word(OP_READ, 6'($urandom), 10'($urandom), 3'($urandom),
                                  1'($urandom), 1'($urandom), 16'($urandom),
                                  16'($urandom)), 1'b0, '0);
            end
        end
    endtask

    // Result side: random back-pressure, plus one long hold on request
    initial begin
        int hold_left;
        int stall_left;
        int r;
        hold_left  = 0;
        stall_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = 100;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (steady) begin
                m_ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    m_ready <= 1'b1;
                end else if (r < 93) begin
                    stall_left = $urandom_range(0, 2);
                    m_ready <= 1'b0;
                end else begin
                    stall_left = $urandom_range(15, 40);
                    m_ready <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : check_reads
        res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_reads.size() == 0) begin
                report_mismatch("result with no read pending, channel",
                                24'(m_read_channel), 24'd0);
            end else begin
                want = pending_reads.pop_front();
                reads_checked++;
                if (m_read_channel !== want.read_channel)
                    report_mismatch("read_channel", 24'(m_read_channel),
                                    24'(want.read_channel));
                if (m_hit_total !== want.hit_total)
                    report_mismatch("hit_total", m_hit_total, want.hit_total);
                if (m_beam_beam_total !== want.beam_beam_total)
                    report_mismatch("beam_beam_total", m_beam_beam_total,
                                    want.beam_beam_total);
                if (m_beam_gas_total !== want.beam_gas_total)
                    report_mismatch("beam_gas_total", m_beam_gas_total,
                                    want.beam_gas_total);
                if (m_events_seen !== want.events_seen)
                    report_mismatch("events_seen", m_events_seen, want.events_seen);
            end
        end
    end

    initial begin
        #4_000_000;
        $display("channel_peak_threshold_flag_counter_core verification failed");
        $finish;
    end

    initial begin
        aresetn             <= 1'b0;
        s_valid             <= 1'b0;
        s_operation         <= OP_SAMPLE;
        s_channel           <= '0;
        s_sample_value      <= '0;
        s_integrator_flag   <= 1'b0;
        s_beam_beam_flag    <= 1'b0;
        s_beam_gas_flag     <= 1'b0;
        s_last_of_channel   <= 1'b0;
        s_last_of_event     <= 1'b0;
        s_pedestal_mean_in  <= '0;
        s_pedestal_sigma_in <= '0;
        cfg_valid           <= 1'b0;
        cfg_index           <= CFG_SIGMA_CUT;
        cfg_data            <= '0;

        cut      = SIGMA_CUT_RST;
        skip_n   = SKIP_RST;
        pk_val   = '0;
        pk_flags = '0;
        ch_fresh = 1'b1;
        wipe_counters();

        // directed words
        plan_check(mk_word(OP_READ, 6'd0, 10'd0, 3'b000, 1'b0, 1'b0, 16'd0, 16'd0),
                   totals(6'd0, 24'd0, 24'd0, 24'd0, 24'd0));
        plan_check(mk_word(OP_READ, 6'd63, 10'd1023, 3'b111, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF),
                   totals(6'd63, 24'd0, 24'd0, 24'd0, 24'd0));
        plan_word(mk_word(OP_LOAD, 6'd5, 10'd0, 3'b000, 1'b0, 1'b0, 16'h0000, 16'h0000));
        plan_word(mk_word(OP_LOAD, 6'd5, 10'd0, 3'b001, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF));
        plan_word(mk_word(OP_LOAD, 6'd63, 10'd0, 3'b000, 1'b0, 1'b0, 16'h0000, 16'h0000));
        plan_word(mk_word(OP_LOAD, 6'd0, 10'd0, 3'b001, 1'b0, 1'b0, 16'h0000, 16'h0000));
        // still inside the default skip window: nothing counted
        plan_word(mk_word(OP_SAMPLE, 6'd5, 10'd1023, 3'b111, 1'b1, 1'b1, 16'd0, 16'd0));
        plan_check(mk_word(OP_READ, 6'd5, 10'd0, 3'b000, 1'b0, 1'b0, 16'd0, 16'd0),
                   totals(6'd5, 24'd0, 24'd0, 24'd0, 24'd1));
        plan_regs(16'd48, 16'd0);
        // tied peaks keep the first sample's flags
        plan_word(mk_word(OP_SAMPLE, 6'd5, 10'd1023, 3'b110, 1'b0, 1'b0, 16'd0, 16'd0));
        plan_word(mk_word(OP_SAMPLE, 6'd5, 10'd1023, 3'b001, 1'b1, 1'b0, 16'd0, 16'd0));
        // latched integrator picks the full-scale pedestal: no hit
        plan_word(mk_word(OP_SAMPLE, 6'd5, 10'd1000, 3'b011, 1'b0, 1'b0, 16'd0, 16'd0));
        plan_word(mk_word(OP_SAMPLE, 6'd5, 10'd0, 3'b100, 1'b1, 1'b0, 16'd0, 16'd0));
        // silent channel
        plan_word(mk_word(OP_SAMPLE, 6'd0, 10'd0, 3'b011, 1'b0, 1'b0, 16'd0, 16'd0));
        plan_word(mk_word(OP_SAMPLE, 6'd0, 10'd0, 3'b000, 1'b1, 1'b0, 16'd0, 16'd0));
        // end of event without end of channel
        plan_word(mk_word(OP_SAMPLE, 6'd63, 10'd1, 3'b100, 1'b0, 1'b1, 16'd0, 16'd0));
        plan_word(mk_word(OP_READ, 6'd5, 10'd0, 3'b000, 1'b0, 1'b0, 16'd0, 16'd0));
        plan_word(mk_word(OP_READ, 6'd63, 10'd0, 3'b000, 1'b0, 1'b0, 16'd0, 16'd0));
        plan_word(mk_word(OP_READ, 6'd0, 10'd0, 3'b000, 1'b0, 1'b0, 16'd0, 16'd0));
        plan_word(mk_word(OP_CLEAR, 6'd0, 10'd0, 3'b000, 1'b0, 1'b0, 16'd0, 16'd0));
        plan_check(mk_word(OP_READ, 6'd5, 10'd0, 3'b000, 1'b0, 1'b0, 16'd0, 16'd0),
                   totals(6'd5, 24'd0, 24'd0, 24'd0, 24'd0));
        plan_regs(16'hABFF, 16'hFFFF);
        plan_word(mk_word(OP_SAMPLE, 6'd63, 10'd1023, 3'b111, 1'b1, 1'b1, 16'd0, 16'd0));
        plan_check(mk_word(OP_READ, 6'd63, 10'd0, 3'b000, 1'b0, 1'b0, 16'd0, 16'd0),
                   totals(6'd63, 24'd0, 24'd0, 24'd0, 24'd1));
        plan_regs(16'h0000, 16'd1);
        plan_word(mk_word(OP_SAMPLE, 6'd63, 10'd1, 3'b000, 1'b1, 1'b0, 16'd0, 16'd0));
        plan_word(mk_word(OP_READ, 6'd63, 10'd0, 3'b000, 1'b0, 1'b0, 16'd0, 16'd0));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // fill every pedestal entry before anything can be scored
        for (int i = 0; i < 2 * CHANNELS; i++)
            send_word(mk_word(OP_LOAD, 6'(i), 10'($urandom), {2'($urandom), 1'(i / CHANNELS)},
                              1'($urandom), 1'($urandom), pick_mean(), pick_sigma()),
                      1'b0, '0);

        foreach (plan_rows[i]) begin
            if (plan_rows[i].kind == ROW_REGS) begin
                drain();
                set_regs(plan_rows[i].cut_data, plan_rows[i].skip_data);
            end else begin
                send_word(plan_rows[i].w, plan_rows[i].typed, plan_rows[i].want);
            end
        end

        drain();
        set_regs(16'd16, 16'd0);
        run_traffic(50);

        drain();
        set_regs(16'($urandom), 16'($urandom_range(1, 4)));
        run_traffic(35);

        drain();
        set_regs(16'($urandom), 16'($urandom_range(0, 2)));
        steady = 1'b1;
        run_traffic(35);

        // long hold on the result side while reads keep coming
        hold_off_req = 1'b1;
        for (int k = 0; k < 30; k++)
            send_word(mk_word(OP_READ, 6'($urandom_range(0, 7)), 10'($urandom), 3'($urandom),
                              1'($urandom), 1'($urandom), 16'($urandom), 16'($urandom)),
                      1'b0, '0);
        steady = 1'b0;

        drain();
        set_regs(16'd48, 16'd0);
        run_traffic(40);

        drain();
        set_regs(16'h00FF, 16'd0);
        run_traffic(30);

        drain();
        $display("covered %0d input words over %0d register settings, %0d reads checked",
                 words_sent, reg_settings, reads_checked);
        $display("%0d channels closed inside the counting window, %0d above threshold",
                 closes_scored, hits_scored);
        if (errors == 0) begin
            $display("channel_peak_threshold_flag_counter_core verification clean");
        end else begin
            $display("channel_peak_threshold_flag_counter_core verification failed");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/ptfc_pkg.sv
rtl/ptfc_ram.sv
rtl/ptfc_cmd_queue.sv
rtl/ptfc_front.sv
rtl/ptfc_back.sv
rtl/channel_peak_threshold_flag_counter_core.sv
verif/tb_channel_peak_threshold_flag_counter_core.sv
